[rtl/sise_pkg.sv]
//------------------------------------------------------------------------------
// sise_pkg
// Shared types and constants for the sorted integer set engine.
//------------------------------------------------------------------------------
package sise_pkg;

	localparam int SET_CAPACITY = 16;

	localparam logic [2:0] OP_ADD       = 3'd0;
	localparam logic [2:0] OP_REMOVE    = 3'd1;
	localparam logic [2:0] OP_PRINT     = 3'd2;
	localparam logic [2:0] OP_UNION     = 3'd3;
	localparam logic [2:0] OP_INTERSECT = 3'd4;

	// command broadcast to every cell of one chain
	// rot: head word wraps to the tail, all others move one slot toward the head
	typedef struct packed {
		logic        ins;
		logic        del;
		logic        rot;
		logic [31:0] value;
	} cell_cmd_t;

endpackage

[rtl/sise_if.sv]
//------------------------------------------------------------------------------
// sise_in_if / sise_out_if
// Valid/ready channels for command words and result words.
//------------------------------------------------------------------------------
interface sise_in_if;
	logic              valid;
	logic              ready;
	logic [2:0]        operation;
	logic              target_set;
	logic signed [31:0] value;
	modport source (output valid, output operation, output target_set, output value,
		input ready);
	modport sink (input valid, input operation, input target_set, input value,
		output ready);
endinterface

interface sise_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] element;
	logic               last;
	modport source (output valid, output element, output last, input ready);
	modport sink (input valid, input element, input last, output ready);
endinterface

[rtl/sise_cell.sv]
//------------------------------------------------------------------------------
// sise_cell
// One slot of a sorted chain. Compares the broadcast value and moves its word
// to or from a neighbor on insert, delete and rotate.
//------------------------------------------------------------------------------
module sise_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  sise_pkg::cell_cmd_t cmd,
	input  logic              left_valid,
	input  logic [31:0]       left_data,
	input  logic              left_gt,
	input  logic              left_hit,
	input  logic              right_valid,
	input  logic [31:0]       right_data,
	output logic              valid,
	output logic [31:0]       data,
	output logic              gt,
	output logic              hit
);

	logic        valid_q;
	logic [31:0] data_q;
	logic        shift_in;
	logic        pull_in;

	assign valid = valid_q;
	assign data  = data_q;
	// signed compare done on offset-binary keys
	assign gt  = valid_q && ((data_q ^ 32'h8000_0000) > (cmd.value ^ 32'h8000_0000));
	assign hit = valid_q && (data_q == cmd.value);

	// insert: this cell and all above the insertion point move up one slot
	assign shift_in = cmd.ins && (gt || !valid_q) && left_valid && left_gt;
	// delete: cells at and above the match pull from the right
	assign pull_in  = cmd.del && (hit || left_hit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pull_in) begin
			valid_q <= right_valid;
		end else if (cmd.ins && !valid_q && left_valid) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pull_in) begin
			data_q <= right_data;
		end else if (cmd.rot && valid_q) begin
			// the tail cell takes the old head, carried on cmd.value
			data_q <= right_valid ? right_data : cmd.value;
		end else if (shift_in) begin
			data_q <= left_data;
		end else if (cmd.ins && (gt || !valid_q) && left_valid) begin
			data_q <= cmd.value;
		end
	end

endmodule

[rtl/sise_chain.sv]
//------------------------------------------------------------------------------
// sise_chain
// A row of cells holding one set in ascending order; cell 0 is the head.
//------------------------------------------------------------------------------
module sise_chain #(
	parameter int Depth = sise_pkg::SET_CAPACITY
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  sise_pkg::cell_cmd_t          cmd,
	output logic [31:0]                  head_data,
	output logic [$clog2(Depth+1)-1:0]   count
);

	localparam int CntW = $clog2(Depth + 1);

	logic [Depth:0]      v;
	logic [Depth:1]      g;
	logic [Depth:0]      h;
	logic [31:0]         d [Depth+1];
	logic [Depth-1:0]    hits;
	logic                present;
	logic                full;
	logic [CntW-1:0]     count_q;
	sise_pkg::cell_cmd_t ccmd;

	// drop inserts of present values and into a full chain
	always_comb begin
		ccmd     = cmd;
		ccmd.ins = cmd.ins && !present && !full;
	end

	assign v[Depth] = 1'b0;
	assign d[Depth] = '0;
	assign h[0] = 1'b0;

	for (genvar i = 0; i < Depth; i++) begin : g_cell
		logic lv;
		logic [31:0] ld;
		logic lg;
		if (i == 0) begin : g_head
			// virtual cell left of the head: always valid, never greater
			assign lv = 1'b1;
			assign ld = '0;
			assign lg = 1'b0;
		end else begin : g_body
			assign lv = v[i-1];
			assign ld = d[i-1];
			assign lg = g[i];
		end
		sise_cell u_cell (
			.clk, .arst_n, .cmd(ccmd),
			.left_valid(lv), .left_data(ld), .left_gt(lg), .left_hit(h[i]),
			.right_valid(v[i+1]), .right_data(d[i+1]),
			.valid(v[i]), .data(d[i]), .gt(g[i+1]), .hit(hits[i])
		);
		// delete-propagate: once a match is seen, all cells to the right pull
		assign h[i+1] = hits[i] || h[i];
	end

	assign present = h[Depth];
	assign full    = v[Depth-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ccmd.ins) begin
			count_q <= count_q + CntW'(1);
		end else if (cmd.del && present) begin
			count_q <= count_q - CntW'(1);
		end
	end

	assign head_data = d[0];
	assign count     = count_q;

endmodule

[rtl/sorted_integer_set_engine.sv]
//------------------------------------------------------------------------------
// sorted_integer_set_engine
// Two sorted sets of signed 32-bit integers with print, union and intersection.
//------------------------------------------------------------------------------
// Each set lives in a chain of SetCapacity cells kept in ascending order. Add and
// remove make every cell compare the value at once and shift by one slot. Print,
// union and intersection walk the chains by rotating them, at most one head per
// chain per cycle and none while stalled, so a full walk puts every chain back in
// order. A query rotates every element of both sets for union and intersection,
// or of the chosen set for print, and stalls while a found word waits on a full
// output register. Each word is held back until the next one is found or the walk
// ends, so the final word can carry last. Commands are accepted only between
// queries; an empty answer gives no word.
module sorted_integer_set_engine #(
	parameter int SetCapacity = sise_pkg::SET_CAPACITY
) (
	input  logic clk,
	input  logic arst_n,
	sise_in_if.sink    in_ch,
	sise_out_if.source out_ch
);

	localparam int CntW = $clog2(SetCapacity + 1);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t              state_q;
	logic [2:0]          op_q;
	logic [CntW-1:0]     rem_x_q, rem_y_q, x_cnt, y_cnt;
	logic                accept, is_query, run;
	sise_pkg::cell_cmd_t cmd_x, cmd_y;
	logic [31:0]         xd, yd, found_data;
	logic                more_x, more_y, x_lt, y_lt;
	logic                want_x, want_y, found;
	logic                step, take_x, take_y, finish, push;
	logic                pend_v_q;
	logic [31:0]         pend_d_q;
	logic                ovalid_q, olast_q;
	logic [31:0]         odata_q;
	logic                out_free;

	assign run         = state_q == ST_RUN;
	assign in_ch.ready = state_q == ST_IDLE;
	assign accept      = in_ch.valid && in_ch.ready;
	assign is_query    = in_ch.operation == sise_pkg::OP_PRINT
		|| in_ch.operation == sise_pkg::OP_UNION
		|| in_ch.operation == sise_pkg::OP_INTERSECT;
	assign out_free    = !ovalid_q || out_ch.ready;

	always_comb begin
		cmd_x = '0;
		cmd_y = '0;
		if (run) begin
			cmd_x.rot   = take_x;
			cmd_x.value = xd;
			cmd_y.rot   = take_y;
			cmd_y.value = yd;
		end else begin
			cmd_x.value = in_ch.value;
			cmd_y.value = in_ch.value;
			cmd_x.ins = accept && in_ch.operation == sise_pkg::OP_ADD && !in_ch.target_set;
			cmd_y.ins = accept && in_ch.operation == sise_pkg::OP_ADD && in_ch.target_set;
			cmd_x.del = accept && in_ch.operation == sise_pkg::OP_REMOVE && !in_ch.target_set;
			cmd_y.del = accept && in_ch.operation == sise_pkg::OP_REMOVE && in_ch.target_set;
		end
	end

	sise_chain #(.Depth(SetCapacity)) u_x (.clk, .arst_n, .cmd(cmd_x),
		.head_data(xd), .count(x_cnt));
	sise_chain #(.Depth(SetCapacity)) u_y (.clk, .arst_n, .cmd(cmd_y),
		.head_data(yd), .count(y_cnt));

	assign more_x = rem_x_q != '0;
	assign more_y = rem_y_q != '0;
	assign x_lt   = $signed(xd) < $signed(yd);
	assign y_lt   = $signed(yd) < $signed(xd);

	always_comb begin
		want_x = 1'b0;
		want_y = 1'b0;
		found  = 1'b0;
		case (op_q)
			sise_pkg::OP_PRINT: begin
				// the other set was given nothing to walk
				want_x = more_x;
				want_y = more_y;
				found  = more_x || more_y;
			end
			sise_pkg::OP_UNION: begin
				want_x = more_x && (!more_y || !y_lt);
				want_y = more_y && (!more_x || !x_lt);
				found  = want_x || want_y;
			end
			sise_pkg::OP_INTERSECT: begin
				if (more_x && more_y) begin
					want_x = !y_lt;
					want_y = !x_lt;
					found  = !x_lt && !y_lt;
				end else begin
					// finish the rotation so the chain is back in order
					want_x = more_x;
					want_y = more_y;
				end
			end
			default: begin
			end
		endcase
	end

	assign found_data = want_x ? xd : yd;
	assign step   = run && !(found && pend_v_q && !out_free);
	assign take_x = step && want_x;
	assign take_y = step && want_y;
	assign finish = run && !more_x && !more_y && (!pend_v_q || out_free);
	assign push   = pend_v_q && ((step && found) || finish);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			op_q     <= sise_pkg::OP_ADD;
			rem_x_q  <= '0;
			rem_y_q  <= '0;
			pend_v_q <= 1'b0;
			ovalid_q <= 1'b0;
			olast_q  <= 1'b0;
		end else begin
			ovalid_q <= push || (ovalid_q && !out_ch.ready);
			if (push) begin
				olast_q <= finish;
			end
			if (step && found) begin
				pend_v_q <= 1'b1;
			end else if (finish) begin
				pend_v_q <= 1'b0;
			end
			if (accept && is_query) begin
				rem_x_q <= (in_ch.operation == sise_pkg::OP_PRINT && in_ch.target_set)
					? '0 : x_cnt;
				rem_y_q <= (in_ch.operation == sise_pkg::OP_PRINT && !in_ch.target_set)
					? '0 : y_cnt;
			end else begin
				rem_x_q <= rem_x_q - CntW'(take_x);
				rem_y_q <= rem_y_q - CntW'(take_y);
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && is_query) begin
						state_q <= ST_RUN;
						op_q    <= in_ch.operation;
					end
				end
				ST_RUN: begin
					if (finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (step && found) begin
			pend_d_q <= found_data;
		end
		if (push) begin
			odata_q <= pend_d_q;
		end
	end

	assign out_ch.valid   = ovalid_q;
	assign out_ch.element = odata_q;
	assign out_ch.last    = olast_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> state_q == ST_IDLE)
		else $error("command accepted during a run");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.ready) |=> out_ch.valid)
		else $error("result word dropped while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.ready) |=> ($stable(out_ch.element) && $stable(out_ch.last)))
		else $error("result word changed while stalled");

endmodule
